// ===== hdl/fit_policy_block_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPBA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPBA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FPBA_ASSERT_IMP(label, ante, cons)
`define FPBA_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/fpba_pkg.sv =====
// Types and constants of the fit-policy block allocator.
package fpba_pkg;

    localparam int FPBA_NUM_BLOCKS = 16;
    localparam int FPBA_SIZE_WIDTH = 16;

    localparam int KIND_W       = 2;
    localparam int IDX_FIELD_W  = 4;
    localparam int SIZE_FIELD_W = 16;
    localparam int CNT_FIELD_W  = 5;
    localparam int MODE_W       = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - 1 - IDX_FIELD_W - SIZE_FIELD_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CNT_FIELD_W-1:0] BLOCK_COUNT_RST = CNT_FIELD_W'(16);

    typedef enum logic [MODE_W-1:0] {
        FIT_BEST  = 2'd0,
        FIT_WORST = 2'd1,
        FIT_FIRST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_REQUEST = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIT_MODE    = 1'd0,
        CFG_BLOCK_COUNT = 1'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_WB   = 2'd2
    } fsm_state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic      load;
        logic      restart;
        logic      commit;
        fit_mode_t mode;
    } fpba_ctrl_t;

endpackage

// ===== hdl/fit_policy_block_allocator.sv =====
// Fit-policy block allocator: controller and chain of table cells.
//
// Input channel s_*: one item per handshake. s_tuser carries the kind (load,
// restart, request); loads and restarts give no result. A request launches a
// search token that walks the row of NUM_BLOCKS cells, one cell per cycle;
// each cell compares its working size and updates the token under the
// current fit mode. After the last cell the controller writes the remainder
// back to the chosen cell and places the result in the output register.
// Timing: an accepted request is registered into the launch register, then the
// token passes each cell's register in turn and the controller captures its
// result; one request is in flight at a time and input reopens the cycle
// after the result loads, so a new request waits until the last one is done.
// Output channel m_*: a held result never blocks input acceptance; only the
// write-back of the next request waits for the output register to drain.
// Reset: fit mode best fit, block count 16, taken marks and next-fit pointer
// cleared. Block sizes are undefined until loaded and restarted.
// Configuration: cfg_we/cfg_index/cfg_data; user writes only while idle, not enforced.
`include "fit_policy_block_allocator_macros.svh"

module fit_policy_block_allocator
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = FPBA_NUM_BLOCKS,
    parameter int SIZE_WIDTH = FPBA_SIZE_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // block_index[3:0], size_value[19:4], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // granted[0], chosen_block[4:1],
                                             // remaining_size[20:5], zero pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int NW = $clog2(NUM_BLOCKS + 1);

    // configuration
    fit_mode_t              mode_reg;
    logic [CNT_FIELD_W-1:0] count_reg;

    // control
    fsm_state_t state_reg;
    fsm_state_t state_next;
    logic       launch_reg;
    logic       s_accept;
    logic       out_free;
    logic       out_load;
    logic       exit_valid;

    kind_t                   in_kind;
    logic [IDX_FIELD_W-1:0]  in_idx;
    logic [SIZE_FIELD_W-1:0] in_size;

    logic [SIZE_WIDTH-1:0] req_reg;
    logic [IW-1:0]         ptr_reg;
    logic [NW-1:0]         blk_n;
    logic [IW-1:0]         start_idx;

    logic                  res_hit_reg;
    logic [IW-1:0]         res_sel_reg;
    logic [SIZE_WIDTH-1:0] res_val_reg;
    logic [SIZE_WIDTH-1:0] remainder;
    logic [NW-1:0]         sel_plus;

    fpba_ctrl_t            ctrl;
    logic [IW-1:0]         wr_idx;
    logic [SIZE_WIDTH-1:0] wr_size;

    // token chain; tap g feeds cell g
    logic                  tok_valid  [0:NUM_BLOCKS];
    logic                  tok_found  [0:NUM_BLOCKS];
    logic [IW-1:0]         tok_sel    [0:NUM_BLOCKS];
    logic [SIZE_WIDTH-1:0] tok_val    [0:NUM_BLOCKS];
    logic                  tok_found2 [0:NUM_BLOCKS];
    logic [IW-1:0]         tok_sel2   [0:NUM_BLOCKS];
    logic [SIZE_WIDTH-1:0] tok_val2   [0:NUM_BLOCKS];
    logic                  token_any;

    // output register
    logic                    m_tvalid_reg;
    logic                    out_granted_reg;
    logic [IDX_FIELD_W-1:0]  out_chosen_reg;
    logic [SIZE_FIELD_W-1:0] out_remain_reg;

    assign in_kind  = kind_t'(s_tuser);
    assign in_idx   = s_tdata[IDX_FIELD_W-1:0];
    assign in_size  = s_tdata[IDX_FIELD_W+SIZE_FIELD_W-1:IDX_FIELD_W];
    assign s_accept = s_tvalid && s_tready;

    // blocks in use, saturated to the table size
    assign blk_n     = (32'(count_reg) > NUM_BLOCKS) ? NW'(NUM_BLOCKS) : NW'(count_reg);
    // stale pointer restarts the next-fit scan at entry zero
    assign start_idx = (NW'(ptr_reg) < blk_n) ? ptr_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= FIT_BEST;
            count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_FIT_MODE:    mode_reg  <= fit_mode_t'(cfg_data[MODE_W-1:0]);
                CFG_BLOCK_COUNT: count_reg <= cfg_data[CNT_FIELD_W-1:0];
                default:         mode_reg  <= mode_reg;
            endcase
        end
    end

    // ---------------- state machine ----------------
    assign exit_valid = tok_valid[NUM_BLOCKS];
    assign out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_accept && in_kind == KIND_REQUEST)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (exit_valid)
                begin
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= s_accept && in_kind == KIND_REQUEST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && in_kind == KIND_REQUEST)
        begin
            req_reg <= SIZE_WIDTH'(in_size);
        end
        // next fit: primary candidate wins over the wrapped one
        if (state_reg == ST_SCAN && exit_valid)
        begin
            res_hit_reg <= tok_found[NUM_BLOCKS] || tok_found2[NUM_BLOCKS];
            res_sel_reg <= tok_found[NUM_BLOCKS] ? tok_sel[NUM_BLOCKS] : tok_sel2[NUM_BLOCKS];
            res_val_reg <= tok_found[NUM_BLOCKS] ? tok_val[NUM_BLOCKS] : tok_val2[NUM_BLOCKS];
        end
    end

    assign remainder = res_val_reg - req_reg;
    assign sel_plus  = NW'(res_sel_reg) + NW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (s_accept && in_kind == KIND_RESTART)
        begin
            ptr_reg <= '0;
        end
        else if (ctrl.commit && mode_reg == FIT_NEXT)
        begin
            ptr_reg <= (sel_plus == blk_n) ? '0 : IW'(sel_plus);
        end
    end

    // ---------------- cell broadcast ----------------
    always_comb
    begin
        ctrl.load    = s_accept && in_kind == KIND_LOAD && (32'(in_idx) < NUM_BLOCKS);
        ctrl.restart = s_accept && in_kind == KIND_RESTART;
        ctrl.commit  = out_load && res_hit_reg;
        ctrl.mode    = mode_reg;
        wr_idx       = ctrl.load ? IW'(in_idx) : res_sel_reg;
        wr_size      = ctrl.load ? SIZE_WIDTH'(in_size) : remainder;
    end

    assign tok_valid[0]  = launch_reg;
    assign tok_found[0]  = 1'b0;
    assign tok_sel[0]    = '0;
    assign tok_val[0]    = '0;
    assign tok_found2[0] = 1'b0;
    assign tok_sel2[0]   = '0;
    assign tok_val2[0]   = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_cell
        fpba_cell #(
            .NUM_BLOCKS (NUM_BLOCKS),
            .SIZE_WIDTH (SIZE_WIDTH),
            .CELL_IDX   (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_idx     (wr_idx),
            .wr_size    (wr_size),
            .req        (req_reg),
            .blk_n      (blk_n),
            .start_idx  (start_idx),
            .in_valid   (tok_valid[g]),
            .in_found   (tok_found[g]),
            .in_sel     (tok_sel[g]),
            .in_val     (tok_val[g]),
            .in_found2  (tok_found2[g]),
            .in_sel2    (tok_sel2[g]),
            .in_val2    (tok_val2[g]),
            .out_valid  (tok_valid[g+1]),
            .out_found  (tok_found[g+1]),
            .out_sel    (tok_sel[g+1]),
            .out_val    (tok_val[g+1]),
            .out_found2 (tok_found2[g+1]),
            .out_sel2   (tok_sel2[g+1]),
            .out_val2   (tok_val2[g+1])
        );
    end

    always_comb
    begin
        token_any = 1'b0;
        for (int i = 0; i <= NUM_BLOCKS; i++)
        begin
            token_any = token_any | tok_valid[i];
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_granted_reg <= res_hit_reg;
            out_chosen_reg  <= res_hit_reg ? IDX_FIELD_W'(res_sel_reg) : '0;
            out_remain_reg  <= res_hit_reg ? SIZE_FIELD_W'(remainder) : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_remain_reg, out_chosen_reg, out_granted_reg};

    // ---------------- checks ----------------
    `FPBA_ASSERT_IMP(a_idle_no_token, s_tready, !token_any)
    `FPBA_ASSERT_IMP(a_exit_in_scan, exit_valid, state_reg == ST_SCAN)
    `FPBA_ASSERT_IMP(a_launch_in_scan, launch_reg, state_reg == ST_SCAN)
    `FPBA_ASSERT_IMP(a_commit_in_range, ctrl.commit, NW'(wr_idx) < blk_n)
    `FPBA_ASSERT_NXT(a_load_shows_result, out_load, m_tvalid)

endmodule

// ===== hdl/fpba_cell.sv =====
// One table cell: holds a block's sizes and evaluates the passing search token.
module fpba_cell
    import fpba_pkg::*;
#(
    parameter int NUM_BLOCKS = FPBA_NUM_BLOCKS,
    parameter int SIZE_WIDTH = FPBA_SIZE_WIDTH,
    parameter int CELL_IDX   = 0
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  fpba_ctrl_t                                    ctrl,
    input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] wr_idx,
    input  logic [SIZE_WIDTH-1:0]                         wr_size,
    input  logic [SIZE_WIDTH-1:0]                         req,
    input  logic [$clog2(NUM_BLOCKS + 1)-1:0]             blk_n,
    input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] start_idx,
    input  logic                                          in_valid,
    input  logic                                          in_found,
    input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] in_sel,
    input  logic [SIZE_WIDTH-1:0]                         in_val,
    input  logic                                          in_found2,
    input  logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] in_sel2,
    input  logic [SIZE_WIDTH-1:0]                         in_val2,
    output logic                                          out_valid,
    output logic                                          out_found,
    output logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] out_sel,
    output logic [SIZE_WIDTH-1:0]                         out_val,
    output logic                                          out_found2,
    output logic [((NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1)-1:0] out_sel2,
    output logic [SIZE_WIDTH-1:0]                         out_val2
);

    localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int NW = $clog2(NUM_BLOCKS + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [SIZE_WIDTH-1:0] loaded_reg;
    logic [SIZE_WIDTH-1:0] working_reg;
    logic                  taken_reg;

    logic                  valid_reg;
    logic                  found_reg;
    logic [IW-1:0]         sel_reg;
    logic [SIZE_WIDTH-1:0] val_reg;
    logic                  found2_reg;
    logic [IW-1:0]         sel2_reg;
    logic [SIZE_WIDTH-1:0] val2_reg;

    logic fits;
    logic take;
    logic take2;
    logic hit_me;

    assign hit_me = (wr_idx == MY_IDX);

    always_comb
    begin
        fits  = (NW'(MY_IDX) < blk_n) && (working_reg >= req);
        take  = 1'b0;
        take2 = 1'b0;
        case (ctrl.mode)
            FIT_BEST:  take = fits && !taken_reg && (!in_found || working_reg <= in_val);
            FIT_WORST: take = fits && (!in_found || working_reg > in_val);
            FIT_FIRST: take = fits && !in_found;
            FIT_NEXT:
            begin
                // primary: first fit at or after start; secondary: first fit anywhere
                take  = fits && (MY_IDX >= start_idx) && !in_found;
                take2 = fits && !in_found2;
            end
            default:
            begin
                take  = 1'b0;
                take2 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg <= 1'b1;
            sel_reg   <= MY_IDX;
            val_reg   <= working_reg;
        end
        else
        begin
            found_reg <= in_found;
            sel_reg   <= in_sel;
            val_reg   <= in_val;
        end
        if (take2)
        begin
            found2_reg <= 1'b1;
            sel2_reg   <= MY_IDX;
            val2_reg   <= working_reg;
        end
        else
        begin
            found2_reg <= in_found2;
            sel2_reg   <= in_sel2;
            val2_reg   <= in_val2;
        end
    end

    // sizes: no reset; the loaded size is defined once loaded, the working size once restarted
    always_ff @(posedge clk)
    begin
        if (ctrl.load && hit_me)
        begin
            loaded_reg <= wr_size;
        end
        if (ctrl.restart)
        begin
            working_reg <= loaded_reg;
        end
        else if (ctrl.commit && hit_me)
        begin
            working_reg <= wr_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else if (ctrl.restart)
        begin
            taken_reg <= 1'b0;
        end
        else if (ctrl.commit && hit_me && ctrl.mode == FIT_BEST)
        begin
            taken_reg <= 1'b1;
        end
    end

    assign out_valid  = valid_reg;
    assign out_found  = found_reg;
    assign out_sel    = sel_reg;
    assign out_val    = val_reg;
    assign out_found2 = found2_reg;
    assign out_sel2   = sel2_reg;
    assign out_val2   = val2_reg;

endmodule
